/* sv/min_max_tracking_stack_macros.svh */
// Assertion macros used by the checker file.
`ifndef MIN_MAX_TRACKING_STACK_MACROS_SVH
`define MIN_MAX_TRACKING_STACK_MACROS_SVH

// Check on every clock edge outside reset.
`define MMTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every clock edge, reset included.
`define MMTS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* sv/mmts_pkg.sv */
package mmts_pkg;

    localparam int TAG_W   = 16;
    localparam int VAL_W   = 32;
    localparam int LEVEL_W = 7;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic        [1:0]       opcode;
        logic        [TAG_W-1:0] item_tag;
        logic signed [VAL_W-1:0] item_value;
    } item_t;

    typedef struct packed {
        logic        [1:0]         status;
        logic        [TAG_W-1:0]   out_tag;
        logic signed [VAL_W-1:0]   out_value;
        logic        [TAG_W-1:0]   max_tag;
        logic signed [VAL_W-1:0]   max_value;
        logic        [TAG_W-1:0]   min_tag;
        logic signed [VAL_W-1:0]   min_value;
        logic                      now_empty;
        logic        [LEVEL_W-1:0] fill_level;
    } result_t;

endpackage

/* sv/mmts_row_ram.sv */
module mmts_row_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/min_max_tracking_stack.sv */
// Min/max tracking stack. A LIFO of (tag, signed value) entries in which every
// level also records the largest and smallest entry at or below it, so each
// result reports the affected entry together with the current maximum and
// minimum. Ties keep the earlier entry. Opcodes: push, pop, peek (the unused
// code behaves as peek). Pop or peek on an empty stack returns the empty status,
// push onto a full stack returns the full status; both leave the stack unchanged
// and report a zero entry. A transaction is accepted in the idle state, which
// also starts the read of the level below the top, and finished in the
// execute state on the registered read data of the row memory. The top row
// is kept in a register, so only pop needs the memory read. A result waits
// in an output register, and the next transaction is accepted while it waits;
// the block stalls in its execute state only if the previous result is held.
// No clearing pass follows reset: only levels below the fill count are used.
module min_max_tracking_stack #(
    parameter int STACK_DEPTH = 64,
    parameter int TAG_BITS    = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mmts_pkg::item_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mmts_pkg::result_t m_data
);

    // Tags wider than the port cannot carry more bits than the port has.
    localparam int TW = (TAG_BITS < mmts_pkg::TAG_W) ? TAG_BITS : mmts_pkg::TAG_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    typedef struct packed {
        logic        [TW-1:0]               tag;
        logic signed [mmts_pkg::VAL_W-1:0] value;
    } slot_t;

    // One memory row: the entry and the running extremes at its level.
    typedef struct packed {
        slot_t entry;
        slot_t hi;
        slot_t lo;
    } row_t;

    logic              state_reg;
    logic [CW-1:0]     fill_reg;
    logic [CW-1:0]     fill_next;
    row_t              top_reg;
    row_t              top_next;
    logic [1:0]        op_reg;
    slot_t             item_reg;
    logic              m_valid_reg;
    mmts_pkg::result_t m_data_reg;
    mmts_pkg::result_t res;

    logic              accept;
    logic              out_free;
    logic              done;
    logic              is_empty;
    logic              is_full;
    logic              wr_op;
    logic              wr_en;
    row_t              push_row;
    row_t              rd_row;
    logic [$bits(row_t)-1:0] rd_bits;
    logic [CW-1:0]     fill_minus2;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    slot_t             out_slot;
    logic [CW+6:0]     fill_ext;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign done     = (state_reg == ST_EXEC) && out_free;

    // Pop exposes the level below the top; fetch it while the transaction lands.
    assign fill_minus2 = fill_reg - CW'(2);
    assign rd_addr     = fill_minus2[AW-1:0];
    assign wr_addr     = fill_reg[AW-1:0];
    assign wr_en       = done && wr_op;
    assign rd_row      = row_t'(rd_bits);

    mmts_row_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (STACK_DEPTH)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_row),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    always_comb begin
        is_empty = (fill_reg == '0);
        is_full  = (fill_reg == CW'(STACK_DEPTH));

        // Strict compares: replace an extreme only on a strictly better value.
        push_row.entry = item_reg;
        push_row.hi    = (is_empty || (item_reg.value > top_reg.hi.value)) ?
                         item_reg : top_reg.hi;
        push_row.lo    = (is_empty || (item_reg.value < top_reg.lo.value)) ?
                         item_reg : top_reg.lo;

        res.status = mmts_pkg::STATUS_OK;
        out_slot   = '0;
        fill_next  = fill_reg;
        top_next   = top_reg;
        wr_op      = 1'b0;

        unique case (op_reg)
            mmts_pkg::OP_PUSH: begin
                if (is_full) begin
                    res.status = mmts_pkg::STATUS_FULL;
                end else begin
                    out_slot  = item_reg;
                    fill_next = fill_reg + CW'(1);
                    top_next  = push_row;
                    wr_op     = 1'b1;
                end
            end
            mmts_pkg::OP_POP: begin
                if (is_empty) begin
                    res.status = mmts_pkg::STATUS_EMPTY;
                end else begin
                    out_slot  = top_reg.entry;
                    fill_next = fill_reg - CW'(1);
                    top_next  = rd_row;
                end
            end
            default: begin
                if (is_empty) begin
                    res.status = mmts_pkg::STATUS_EMPTY;
                end else begin
                    out_slot = top_reg.entry;
                end
            end
        endcase

        res.out_tag   = mmts_pkg::TAG_W'(out_slot.tag);
        res.out_value = out_slot.value;
        res.now_empty = (fill_next == '0);
        // Report zero extremes once the stack has drained.
        if (res.now_empty) begin
            res.max_tag   = '0;
            res.max_value = '0;
            res.min_tag   = '0;
            res.min_value = '0;
        end else begin
            res.max_tag   = mmts_pkg::TAG_W'(top_next.hi.tag);
            res.max_value = top_next.hi.value;
            res.min_tag   = mmts_pkg::TAG_W'(top_next.lo.tag);
            res.min_value = top_next.lo.value;
        end
        fill_ext       = {7'b0, fill_next};
        res.fill_level = fill_ext[mmts_pkg::LEVEL_W-1:0];
    end

    // Control: hold the sequencer state, fill count and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (done) begin
                fill_reg    <= fill_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: capture the transaction, advance the cached top, latch the result.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg         <= s_data.opcode;
            item_reg.tag   <= s_data.item_tag[TW-1:0];
            item_reg.value <= s_data.item_value;
        end
        if (done) begin
            top_reg    <= top_next;
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* sv/mmts_checker.sv */
`include "min_max_tracking_stack_macros.svh"

module mmts_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input mmts_pkg::result_t m_data
);

    `MMTS_ASSERT(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_data)), "result dropped or changed while stalled")
    `MMTS_ASSERT(a_empty_zero, (m_valid && m_data.now_empty) |-> (m_data.max_tag == '0 && m_data.max_value == '0 && m_data.min_tag == '0 && m_data.min_value == '0), "extremes not zero on empty stack")
    `MMTS_ASSERT(a_error_zero, (m_valid && m_data.status != mmts_pkg::STATUS_OK) |-> (m_data.out_tag == '0 && m_data.out_value == '0), "entry not zero on error status")
    `MMTS_ASSERT(a_min_le_max, (m_valid && !m_data.now_empty) |-> (m_data.min_value <= m_data.max_value), "minimum above maximum")
    `MMTS_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind min_max_tracking_stack mmts_checker u_mmts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
